// ===== rtl/hci_event_response_deframer_defines.svh =====
`ifndef HCI_EVENT_RESPONSE_DEFRAMER_DEFINES_SVH
`define HCI_EVENT_RESPONSE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCIERD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCIERD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hcierd_pkg.sv =====
package hcierd_pkg;

	localparam logic [7:0] EVENT_TYPE = 8'h04;

	// Command-complete pattern of a read-version answer, packet bytes 2 to 5
	localparam logic [7:0] VER_PAT0 = 8'h01;
	localparam logic [7:0] VER_PAT1 = 8'h01;
	localparam logic [7:0] VER_PAT2 = 8'h10;
	localparam logic [7:0] VER_PAT3 = 8'h00;

	localparam logic [7:0] IDX_CODE     = 8'd0;
	localparam logic [7:0] IDX_CHECK_LO = 8'd2;
	localparam logic [7:0] IDX_CHECK_HI = 8'd5;
	localparam logic [7:0] IDX_VER_LO   = 8'd12;
	localparam logic [7:0] IDX_VER_HI   = 8'd13;
	localparam logic [7:0] IDX_MAX      = 8'd255;
	localparam logic [7:0] HEADER_LEN   = 8'd2;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_VERSION = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]      header_code;
		logic [3:0][7:0] check;
		logic [1:0][7:0] version;
	} snap_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  event_code;
		logic [7:0]  status_code;
		logic [15:0] version_word;
		logic [4:0]  chip_id;
		logic [3:0]  major_version;
		logic [6:0]  minor_version;
	} result_t;

endpackage

// ===== rtl/hcierd_framer.sv =====
module hcierd_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	output logic                done,
	output hcierd_pkg::snap_t   snap
);

	hcierd_pkg::phase_t phase_q, phase_d;
	logic [7:0]         left_q, left_d, left_dec;
	logic [7:0]         idx_q, idx_d;
	hcierd_pkg::snap_t  snap_q, snap_d, snap_k;
	logic               done_c;

	assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

	// Store the current byte at its place in the packet
	always_comb begin
		snap_k = snap_q;
		if (idx_q == hcierd_pkg::IDX_CODE) begin
			snap_k.header_code = byte_in;
		end else if (idx_q inside {[hcierd_pkg::IDX_CHECK_LO:hcierd_pkg::IDX_CHECK_HI]}) begin
			snap_k.check[2'(idx_q - hcierd_pkg::IDX_CHECK_LO)] = byte_in;
		end else if (idx_q inside {hcierd_pkg::IDX_VER_LO, hcierd_pkg::IDX_VER_HI}) begin
			snap_k.version[idx_q[0]] = byte_in;
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			hcierd_pkg::PH_HEADER: begin
				if (idx_q != 8'd0) begin
					phase_d = (byte_in == 8'd0) ? hcierd_pkg::PH_WAIT : hcierd_pkg::PH_DATA;
				end
			end
			hcierd_pkg::PH_DATA: begin
				if (left_dec == 8'd0) begin
					phase_d = hcierd_pkg::PH_WAIT;
				end
			end
			default: begin
				phase_d = (byte_in == hcierd_pkg::EVENT_TYPE) ?
					hcierd_pkg::PH_HEADER : hcierd_pkg::PH_WAIT;
			end
		endcase
	end

	always_comb begin
		left_d = left_q;
		idx_d  = idx_q;
		snap_d = snap_q;
		done_c = 1'b0;
		case (phase_q)
			hcierd_pkg::PH_HEADER: begin
				snap_d = snap_k;
				idx_d  = (idx_q != hcierd_pkg::IDX_MAX) ? idx_q + 8'd1 : idx_q;
				if (idx_q != 8'd0) begin
					left_d = byte_in;
					done_c = (byte_in == 8'd0);
				end
			end
			hcierd_pkg::PH_DATA: begin
				snap_d = snap_k;
				idx_d  = (idx_q != hcierd_pkg::IDX_MAX) ? idx_q + 8'd1 : idx_q;
				left_d = left_dec;
				done_c = (left_dec == 8'd0);
			end
			default: begin
				// Packet start: clear what a short packet would leave unread
				if (byte_in == hcierd_pkg::EVENT_TYPE) begin
					left_d = hcierd_pkg::HEADER_LEN;
					idx_d  = 8'd0;
					snap_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcierd_pkg::PH_WAIT;
			left_q  <= 8'd0;
			idx_q   <= 8'd0;
			snap_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			snap_q  <= snap_d;
		end
	end

	assign done = step && done_c;
	assign snap = snap_d;

endmodule

// ===== rtl/hcierd_decode.sv =====
module hcierd_decode (
	input  hcierd_pkg::snap_t   snap,
	output hcierd_pkg::result_t result
);

	logic        is_ver;
	logic [15:0] word;

	assign is_ver = (snap.check[0] == hcierd_pkg::VER_PAT0) &&
	                (snap.check[1] == hcierd_pkg::VER_PAT1) &&
	                (snap.check[2] == hcierd_pkg::VER_PAT2) &&
	                (snap.check[3] == hcierd_pkg::VER_PAT3);
	assign word = {snap.version[1], snap.version[0]};

	always_comb begin
		result             = '0;
		result.event_code  = snap.header_code;
		result.status_code = snap.check[3];
		if (is_ver) begin
			result.kind          = hcierd_pkg::KIND_VERSION;
			result.version_word  = word;
			result.chip_id       = word[14:10];
			result.major_version = {word[15], word[9:7]};
			result.minor_version = word[6:0];
		end else if (snap.check[3] != 8'd0) begin
			result.kind = hcierd_pkg::KIND_REJECT;
		end else begin
			result.kind = hcierd_pkg::KIND_ACCEPT;
		end
	end

endmodule

// ===== rtl/hci_event_response_deframer.sv =====
// After the accept of a packet's last byte, result valid follows through the input register,
// then the result register, when the result register is free.
// Throughput: one byte per cycle unless a held result stalls it; the framer state is registered.
// A result the receiver has not yet taken holds the input register and the framer.
// Reset (arst_n low, asynchronous): waits for a packet type, counters and stored bytes
// cleared, no result pending.
`include "hci_event_response_deframer_defines.svh"

module hci_event_response_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  response_kind,
	output logic [7:0]  event_code,
	output logic [7:0]  status_code,
	output logic [15:0] version_word,
	output logic [4:0]  chip_id,
	output logic [3:0]  major_version,
	output logic [6:0]  minor_version
);

	logic                rx_valid_s1;
	logic [7:0]          rx_byte_s1;
	logic                advance;
	logic                step;
	logic                done;
	hcierd_pkg::snap_t   snap;
	hcierd_pkg::result_t result;
	logic                rsp_valid_q;
	hcierd_pkg::result_t rsp_q;

	assign advance  = !rsp_valid_q || rsp_ready;
	assign step     = rx_valid_s1 && advance;
	assign rx_ready = !rx_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	hcierd_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (rx_byte_s1),
		.done    (done),
		.snap    (snap)
	);

	hcierd_decode u_decode (
		.snap   (snap),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign response_kind = rsp_q.kind;
	assign event_code    = rsp_q.event_code;
	assign status_code   = rsp_q.status_code;
	assign version_word  = rsp_q.version_word;
	assign chip_id       = rsp_q.chip_id;
	assign major_version = rsp_q.major_version;
	assign minor_version = rsp_q.minor_version;

	`HCIERD_ASSERT_NOW(a_ready_only_blocked_by_s1, !rx_ready,
		rx_valid_s1 && rsp_valid_q, "input stalled without a held item")
	`HCIERD_ASSERT_NOW(a_kind_legal, rsp_valid_q, rsp_q.kind != 2'd3, "unused result kind")
	`HCIERD_ASSERT_NOW(a_chip_from_word,
		rsp_valid_q && rsp_q.kind == hcierd_pkg::KIND_VERSION,
		rsp_q.chip_id == rsp_q.version_word[14:10], "chip id does not match version word")
	`HCIERD_ASSERT_NOW(a_no_word_otherwise,
		rsp_valid_q && rsp_q.kind != hcierd_pkg::KIND_VERSION,
		rsp_q.version_word == 16'd0 && rsp_q.major_version == 4'd0,
		"version fields set on a non-version result")
	`HCIERD_ASSERT_NEXT(a_done_loads_result, done, rsp_valid_q, "finished packet gave no result")

endmodule

// ===== sim/hci_event_response_checker.sv =====
`timescale 1ns / 100ps

module hci_event_response_checker
	import hcierd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [1:0]  response_kind,
	input  logic [7:0]  event_code,
	input  logic [7:0]  status_code,
	input  logic [15:0] version_word,
	input  logic [4:0]  chip_id,
	input  logic [3:0]  major_version,
	input  logic [6:0]  minor_version,
	output int unsigned failures,
	output int unsigned outstanding
);

	phase_t     phase;
	logic [7:0] bytes_left;
	logic [7:0] byte_index;
	logic [7:0] header_code;
	logic [7:0] check_bytes [4];
	logic [7:0] version_bytes [2];

	result_t     expected_responses [$];
	int unsigned fault_total = 0;

	function automatic void clear_packet();
		byte_index  = '0;
		header_code = '0;
		for (int i = 0; i < 4; i++)
			check_bytes[i] = '0;
		version_bytes[0] = '0;
		version_bytes[1] = '0;
	endfunction

	function automatic void keep_packet_byte(input logic [7:0] b);
		if (byte_index == IDX_CODE)
			header_code = b;
		else if (byte_index >= IDX_CHECK_LO && byte_index <= IDX_CHECK_HI)
			check_bytes[2'(byte_index - IDX_CHECK_LO)] = b;
		else if (byte_index == IDX_VER_LO || byte_index == IDX_VER_HI)
			version_bytes[1'(byte_index - IDX_VER_LO)] = b;
		// saturate so that very long packets never wrap back onto the header
		if (byte_index != IDX_MAX)
			byte_index = byte_index + 8'd1;
	endfunction

	function automatic result_t close_packet();
		result_t     rsp;
		logic [15:0] word;
		rsp = '0;
		rsp.event_code  = header_code;
		rsp.status_code = check_bytes[3];
		if (check_bytes[0] == VER_PAT0 && check_bytes[1] == VER_PAT1 &&
				check_bytes[2] == VER_PAT2 && check_bytes[3] == VER_PAT3) begin
			word              = {version_bytes[1], version_bytes[0]};
			rsp.kind          = KIND_VERSION;
			rsp.version_word  = word;
			rsp.chip_id       = word[14:10];
			rsp.major_version = {word[15], word[9:7]};
			rsp.minor_version = word[6:0];
		end else if (check_bytes[3] != 8'd0) begin
			rsp.kind = KIND_REJECT;
		end else begin
			rsp.kind = KIND_ACCEPT;
		end
		phase      = PH_WAIT;
		bytes_left = '0;
		return rsp;
	endfunction

	// Advance the deframer by one received byte; returns 1 when a packet closes.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t rsp);
		rsp = '0;
		case (phase)
			PH_HEADER: begin
				keep_packet_byte(b);
				if (byte_index >= HEADER_LEN) begin
					if (b == 8'd0) begin
						rsp = close_packet();
						return 1'b1;
					end
					bytes_left = b;
					phase      = PH_DATA;
				end
				return 1'b0;
			end
			PH_DATA: begin
				keep_packet_byte(b);
				if (bytes_left != 8'd0)
					bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0) begin
					rsp = close_packet();
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				phase = PH_WAIT;
				if (b == EVENT_TYPE) begin
					phase      = PH_HEADER;
					bytes_left = HEADER_LEN;
					clear_packet();
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fault_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t predicted;
		result_t want;
		if (!arst_n) begin
			phase      = PH_WAIT;
			bytes_left = '0;
			clear_packet();
			expected_responses.delete();
		end else begin
			if (rx_valid && rx_ready) begin
				if (deframe_byte(rx_byte, predicted))
					expected_responses.push_back(predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_responses.size() == 0) begin
					$error("response with none expected: kind %0d code %0h",
						response_kind, event_code);
					fault_total++;
				end else begin
					want = expected_responses.pop_front();
					report_field("response_kind", 16'(want.kind), 16'(response_kind));
					report_field("event_code", 16'(want.event_code), 16'(event_code));
					report_field("status_code", 16'(want.status_code),
						16'(status_code));
					report_field("version_word", want.version_word, version_word);
					report_field("chip_id", 16'(want.chip_id), 16'(chip_id));
					report_field("major_version", 16'(want.major_version),
						16'(major_version));
					report_field("minor_version", 16'(want.minor_version),
						16'(minor_version));
				end
			end
		end
		outstanding <= expected_responses.size();
		failures    <= fault_total;
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import hcierd_pkg::*;

	localparam int BYTE_TARGET = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM   = 1100;
	localparam int CALM_TO     = 1500;
	localparam int DRAIN_WAIT  = 10;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        rx_valid  = 1'b0;
	logic [7:0]  rx_byte   = '0;
	logic        rsp_ready = 1'b0;
	logic        rx_ready;
	logic        rsp_valid;
	logic [1:0]  response_kind;
	logic [7:0]  event_code;
	logic [7:0]  status_code;
	logic [15:0] version_word;
	logic [4:0]  chip_id;
	logic [3:0]  major_version;
	logic [6:0]  minor_version;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned bytes_sent = 0;

	always #4 clk = ~clk;

	hci_event_response_deframer dut (
		.clk, .arst_n,
		.rx_valid, .rx_ready, .rx_byte,
		.rsp_valid, .rsp_ready,
		.response_kind, .event_code, .status_code, .version_word,
		.chip_id, .major_version, .minor_version
	);

	hci_event_response_checker checker_i (
		.clk, .arst_n,
		.rx_valid, .rx_ready, .rx_byte,
		.rsp_valid, .rsp_ready,
		.response_kind, .event_code, .status_code, .version_word,
		.chip_id, .major_version, .minor_version,
		.failures, .outstanding
	);

	// stretch of the stream in which neither side idles
	function automatic bit calm();
		return bytes_sent >= CALM_FROM && bytes_sent < CALM_TO;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!calm() && $urandom_range(99) < 12) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [7:0] code, input logic [7:0] len,
			input bit versioned, input logic [7:0] status, input logic [15:0] word);
		logic [7:0] b;
		send_byte(EVENT_TYPE);
		send_byte(code);
		send_byte(len);
		for (int i = 2; i < int'(len) + 2; i++) begin
			b = 8'($urandom_range(255));
			if (i == 5)
				b = status;
			else if (versioned && i == 2)
				b = VER_PAT0;
			else if (versioned && i == 3)
				b = VER_PAT1;
			else if (versioned && i == 4)
				b = VER_PAT2;
			else if (versioned && i == 12)
				b = word[7:0];
			else if (versioned && i == 13)
				b = word[15:8];
			send_byte(b);
		end
	endtask

	// Receiver: random stalls, one long hold-off so the block backs up.
	initial begin
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_sent >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm() || $urandom_range(99) >= 12;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: errors");
		$finish;
	end

	initial begin
		int unsigned pick;
		logic [7:0]  len;
		logic [7:0]  status;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// noise, empty packet, full-scale version answer, short rejected packet
		send_byte(8'h00);
		send_byte(8'hFF);
		send_packet(8'hFF, 8'd0, 1'b0, 8'h00, 16'h0000);
		send_packet(8'h0E, 8'd12, 1'b1, VER_PAT3, 16'hFFFF);
		send_packet(8'h0E, 8'd4, 1'b1, 8'hFF, 16'h0000);

		while (bytes_sent < BYTE_TARGET) begin
			// line noise between packets, now and then a stray packet type
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(4, 1))
					send_byte(8'($urandom_range(255)));
			end
			pick = $urandom_range(99);
			if (pick < 8)
				len = 8'd0;
			else if (pick < 16)
				len = 8'($urandom_range(3, 1));
			else if (pick < 97)
				len = 8'($urandom_range(24, 4));
			else if (pick < 99)
				len = 8'($urandom_range(254, 100));
			else
				len = 8'd255;
			status = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
			send_packet($urandom_range(3) != 0 ? 8'h0E : 8'($urandom_range(255)), len,
				$urandom_range(99) < 45, status, 16'($urandom));
		end
		@(negedge clk);
		rx_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (failures == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== hci_event_response_deframer.f =====
+incdir+rtl
rtl/hcierd_pkg.sv
rtl/hcierd_framer.sv
rtl/hcierd_decode.sv
rtl/hci_event_response_deframer.sv
sim/hci_event_response_checker.sv
sim/tb.sv
